// ----- sv/ssp_pkg.sv -----
package ssp_pkg;

  localparam int unsigned MaxItems = 32;
  localparam int unsigned IdxW     = $clog2(MaxItems);
  localparam int unsigned CntW     = $clog2(MaxItems + 1);
  localparam int unsigned KeyW     = 4;
  localparam int unsigned TagW     = 16;
  localparam int unsigned CmpW     = 11;

  typedef logic [1:0] addr_sel_t;

  localparam addr_sel_t AddrI     = 2'd0;
  localparam addr_sel_t AddrINext = 2'd1;
  localparam addr_sel_t AddrJNext = 2'd2;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } rec_t;

  typedef struct packed {
    logic      load_en;
    logic      cmp_clr;
    logic      i_clr;
    logic      i_inc;
    logic      rd_en;
    addr_sel_t addr_sel;
    logic      first;
    logic      scan;
    logic      wr_i;
    logic      wr_best;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_end;
    logic sort_end;
    logic emit_end;
  } sts_t;

endpackage

// ----- sv/ssp_if.sv -----
interface ssp_in_if;
  logic                      valid;
  logic                      ready;
  logic [ssp_pkg::KeyW-1:0]  priority_req;
  logic [ssp_pkg::TagW-1:0]  tag;
  logic                      last_item;

  modport source (output valid, priority_req, tag, last_item, input ready);
  modport sink (input valid, priority_req, tag, last_item, output ready);
endinterface

interface ssp_out_if;
  logic                      valid;
  logic                      ready;
  logic [ssp_pkg::KeyW-1:0]  sorted_priority;
  logic [ssp_pkg::TagW-1:0]  sorted_tag;
  logic [ssp_pkg::CmpW-1:0]  comparisons;
  logic                      items_dropped;
  logic                      last_result;

  modport source (output valid, sorted_priority, sorted_tag, comparisons, items_dropped,
                  last_result, input ready);
  modport sink (input valid, sorted_priority, sorted_tag, comparisons, items_dropped,
                last_result, output ready);
endinterface

// ----- sv/ssp_datapath.sv -----
module ssp_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ssp_pkg::cmd_t             cmd_i,
  output ssp_pkg::sts_t             sts_o,
  input  logic [ssp_pkg::KeyW-1:0]  priority_req_i,
  input  logic [ssp_pkg::TagW-1:0]  tag_i,
  output logic [ssp_pkg::KeyW-1:0]  sorted_priority_o,
  output logic [ssp_pkg::TagW-1:0]  sorted_tag_o,
  output logic [ssp_pkg::CmpW-1:0]  comparisons_o,
  output logic                      items_dropped_o,
  output logic                      last_result_o
);

  ssp_pkg::rec_t                   mem_q [ssp_pkg::MaxItems];
  ssp_pkg::rec_t                   rd_q;
  ssp_pkg::rec_t                   best_q;
  ssp_pkg::rec_t                   cur_q;
  ssp_pkg::rec_t                   wdata;
  logic [ssp_pkg::IdxW-1:0]        raddr;
  logic [ssp_pkg::IdxW-1:0]        waddr;
  logic                            we;
  logic [ssp_pkg::IdxW-1:0]        i_q;
  logic [ssp_pkg::IdxW-1:0]        j_q;
  logic [ssp_pkg::IdxW-1:0]        best_idx_q;
  logic [ssp_pkg::CntW-1:0]        count_q;
  logic [ssp_pkg::CntW-1:0]        n_last;
  logic [ssp_pkg::CntW-1:0]        i_ext;
  logic [ssp_pkg::CntW-1:0]        j_ext;
  logic [ssp_pkg::CmpW-1:0]        cmp_q;
  logic                            ovf_q;
  logic                            full;

  assign full   = (count_q == ssp_pkg::CntW'(ssp_pkg::MaxItems));
  assign n_last = count_q - ssp_pkg::CntW'(1);
  assign i_ext  = ssp_pkg::CntW'(i_q);
  assign j_ext  = ssp_pkg::CntW'(j_q);

  assign sts_o.empty    = (count_q == '0);
  assign sts_o.scan_end = (j_ext == n_last);
  assign sts_o.sort_end = ((i_ext + ssp_pkg::CntW'(2)) >= count_q);
  assign sts_o.emit_end = (i_ext == n_last);

  always_comb begin
    unique case (cmd_i.addr_sel)
      ssp_pkg::AddrI:     raddr = i_q;
      ssp_pkg::AddrINext: raddr = i_q + 1'b1;
      ssp_pkg::AddrJNext: raddr = j_q + 1'b1;
      default:            raddr = i_q;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = i_q;
    wdata = best_q;
    priority if (cmd_i.load_en) begin
      we    = !full;
      waddr = count_q[ssp_pkg::IdxW-1:0];
      wdata = '{key: priority_req_i, tag: tag_i};
    end else if (cmd_i.wr_i) begin
      we    = 1'b1;
      waddr = i_q;
      wdata = best_q;
    end else if (cmd_i.wr_best) begin
      we    = 1'b1;
      waddr = best_idx_q;
      wdata = cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.first) begin
      best_q     <= rd_q;
      cur_q      <= rd_q;
      best_idx_q <= i_q;
      j_q        <= i_q + 1'b1;
    end else if (cmd_i.scan) begin
      if (rd_q.key < best_q.key) begin
        best_q     <= rd_q;
        best_idx_q <= j_q;
      end
      j_q <= j_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      cmp_q   <= '0;
    end else begin
      if (cmd_i.finish) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.load_en) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.cmp_clr) begin
        cmp_q <= '0;
      end else if (cmd_i.scan) begin
        cmp_q <= cmp_q + 1'b1;
      end
    end
  end

  assign sorted_priority_o = rd_q.key;
  assign sorted_tag_o      = rd_q.tag;
  assign comparisons_o     = cmp_q;
  assign items_dropped_o   = ovf_q;
  assign last_result_o     = sts_o.emit_end;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ssp_pkg::CntW'(ssp_pkg::MaxItems))
    else $error("Record count exceeds the store depth.");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (j_ext < count_q))
    else $error("Scan reads beyond the held records.");

  a_first_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.first |-> ((i_ext + ssp_pkg::CntW'(1)) < count_q))
    else $error("A pass starts at a position with nothing after it.");
`endif

endmodule

// ----- sv/ssp_ctrl.sv -----
module ssp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ssp_pkg::sts_t sts_i,
  output ssp_pkg::cmd_t cmd_o
);

  localparam logic [2:0] SLoad   = 3'd0;
  localparam logic [2:0] SPick   = 3'd1;
  localparam logic [2:0] SFirst  = 3'd2;
  localparam logic [2:0] SScan   = 3'd3;
  localparam logic [2:0] SSwapI  = 3'd4;
  localparam logic [2:0] SSwapB  = 3'd5;
  localparam logic [2:0] SEmitRd = 3'd6;
  localparam logic [2:0] SEmit   = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      SLoad: begin
        in_ready_o    = 1'b1;
        cmd_o.load_en = in_valid_i;
        if (in_valid_i && in_last_i) begin
          cmd_o.i_clr   = 1'b1;
          cmd_o.cmp_clr = 1'b1;
          state_d       = sts_i.empty ? SEmitRd : SPick;
        end
      end
      SPick: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = ssp_pkg::AddrI;
        state_d        = SFirst;
      end
      SFirst: begin
        cmd_o.first    = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = ssp_pkg::AddrINext;
        state_d        = SScan;
      end
      SScan: begin
        cmd_o.scan     = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = ssp_pkg::AddrJNext;
        if (sts_i.scan_end) begin
          state_d = SSwapI;
        end
      end
      SSwapI: begin
        cmd_o.wr_i = 1'b1;
        state_d    = SSwapB;
      end
      SSwapB: begin
        cmd_o.wr_best = 1'b1;
        if (sts_i.sort_end) begin
          cmd_o.i_clr = 1'b1;
          state_d     = SEmitRd;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = SPick;
        end
      end
      SEmitRd: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = ssp_pkg::AddrI;
        state_d        = SEmit;
      end
      SEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.emit_end) begin
            cmd_o.finish = 1'b1;
            state_d      = SLoad;
          end else begin
            cmd_o.i_inc    = 1'b1;
            cmd_o.rd_en    = 1'b1;
            cmd_o.addr_sel = ssp_pkg::AddrINext;
          end
        end
      end
      default: begin
        state_d = SLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Input and output sides are open at the same time.");
`endif

endmodule

// ----- sv/selection_sort_by_priority.sv -----
// Records of a 4-bit priority and a 16-bit tag are loaded one per cycle into a 32-entry
// store; records arriving when the store is full are discarded and flagged. The
// transaction marked last starts an ascending selection sort, after which the records
// come out in order, one per cycle while the sink is ready, each carrying the comparison
// count n(n-1)/2 and the dropped flag. The store has a single read port, and the output
// starts with a read of the first record once the sort is done; no input is accepted
// from the last record until the final result has been taken.
module selection_sort_by_priority (
  input logic       clk_i,
  input logic       rst_ni,
  ssp_in_if.sink    in_ch,
  ssp_out_if.source out_ch
);

  ssp_pkg::cmd_t cmd;
  ssp_pkg::sts_t sts;

  ssp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_last_i   (in_ch.last_item),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ssp_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .priority_req_i    (in_ch.priority_req),
    .tag_i             (in_ch.tag),
    .sorted_priority_o (out_ch.sorted_priority),
    .sorted_tag_o      (out_ch.sorted_tag),
    .comparisons_o     (out_ch.comparisons),
    .items_dropped_o   (out_ch.items_dropped),
    .last_result_o     (out_ch.last_result)
  );

endmodule
